### rtl/alm_pkg.sv
`timescale 1ns / 1ps

package alm_pkg;

	// Field widths of the request and response words.
	localparam int ELEM_W  = 32;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
	localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [ELEM_W-1:0] elem_value;
	} req_word_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] occurrences;
		logic [COUNT_W-1:0] elem_total;
		logic               is_empty;
	} rsp_word_t;

endpackage

### rtl/alm_store.sv
`timescale 1ns / 1ps

module alm_store #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
	output logic [VALUE_BITS-1:0]         rd_value,
	output logic [$clog2(CAPACITY):0]     rd_link,
	input  logic                          val_we,
	input  logic [$clog2(CAPACITY)-1:0]   val_addr,
	input  logic [VALUE_BITS-1:0]         val_wdata,
	input  logic                          lnk_we,
	input  logic [$clog2(CAPACITY)-1:0]   lnk_addr,
	input  logic [$clog2(CAPACITY):0]     lnk_wdata
);

	localparam int LW = $clog2(CAPACITY) + 1;

	logic [VALUE_BITS-1:0] val_mem [CAPACITY];
	logic [LW-1:0]         lnk_mem [CAPACITY];

	// Value memory write port.
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_addr] <= val_wdata;
		end
	end

	// Link memory write port.
	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_addr] <= lnk_wdata;
		end
	end

	// Both memories are read at the same slot, with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_value <= val_mem[rd_addr];
			rd_link  <= lnk_mem[rd_addr];
		end
	end

endmodule

### rtl/array_linked_multiset.sv
`timescale 1ns / 1ps

// Multiset of signed values kept as a singly linked list in a node store of
// CAPACITY slots, with unused slots chained on a free list. Each request word
// adds a value at the list head, removes the first match, searches for a
// value or counts its occurrences, and gives one response word with the
// status and the element count after the request. After reset the block
// chains every slot onto the free list and holds req_stall high meanwhile.
// Timing is set by the walk through the node store, one linked node read per
// cycle. An add writes the node in S_ADD and a refused add goes straight to
// S_FIN, where the response enters the output register once it is free.
// Remove, search and count on an empty list also go straight to S_FIN.
// Otherwise they walk the list in S_WALK, visiting at most CAPACITY nodes,
// and a remove that unlinks a node releases it in S_FREE before S_FIN. A new
// request word is accepted once the previous response sits in the output
// register, even while it is stalled.
module array_linked_multiset #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  alm_pkg::req_word_t req_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output alm_pkg::rsp_word_t rsp_word
);

	import alm_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int LW = SW + 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
	localparam logic [CW-1:0] WALK_MAX  = CW'(CAPACITY);
	localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_FREE = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]            state_q;
	logic [SW-1:0]         init_idx_q;
	logic [LW-1:0]         list_head_q;
	logic [LW-1:0]         free_head_q;
	logic [CW-1:0]         total_q;
	logic [REQ_W-1:0]      req_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [LW-1:0]         cur_q;
	logic [LW-1:0]         prev_q;
	logic [CW-1:0]         steps_q;
	logic [CW-1:0]         found_q;
	logic [STAT_W-1:0]     status_q;
	logic                  rsp_valid_q;
	rsp_word_t             rsp_word_q;

	logic                  accept;
	logic [63:0]           in_ext;
	logic [VALUE_BITS-1:0] in_val;
	logic                  hit;
	logic [CW-1:0]         next_steps;
	logic                  walk_stop;
	logic [STAT_W-1:0]     fin_status;
	logic                  rsp_free;

	logic                  rd_en;
	logic [SW-1:0]         rd_addr;
	logic [VALUE_BITS-1:0] rd_value;
	logic [LW-1:0]         rd_link;
	logic                  val_we;
	logic                  lnk_we;
	logic [SW-1:0]         lnk_addr;
	logic [LW-1:0]         lnk_wdata;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// The value is sign extended and kept in its low VALUE_BITS bits.
	assign in_ext = {{(64 - ELEM_W){req_word.elem_value[ELEM_W-1]}}, req_word.elem_value};
	assign in_val = in_ext[VALUE_BITS-1:0];

	// Walk step on the node whose data returned this cycle.
	assign hit        = (rd_value == val_q);
	assign next_steps = steps_q + CW'(1);
	assign walk_stop  = (next_steps == WALK_MAX) || (rd_link >= NULL_LINK);
	assign fin_status = (req_q == REQ_ADD) ? status_q :
	                    ((found_q != '0) ? ST_DONE : ST_MISSING);

	// Node store read address follows the walk.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_link[SW-1:0];
		if (state_q == S_IDLE) begin
			rd_en   = accept;
			rd_addr = (req_word.req_type == REQ_ADD) ? free_head_q[SW-1:0]
			                                         : list_head_q[SW-1:0];
		end else if (state_q == S_WALK) begin
			rd_en = !walk_stop && !(hit && (req_q == REQ_REMOVE || req_q == REQ_SEARCH));
		end
	end

	// Value and link memory writes: free list chaining, add, unlink and release.
	always_comb begin
		val_we    = (state_q == S_ADD);
		lnk_we    = 1'b0;
		lnk_addr  = cur_q[SW-1:0];
		lnk_wdata = free_head_q;
		unique case (state_q)
			S_INIT: begin
				lnk_we    = 1'b1;
				lnk_addr  = init_idx_q;
				lnk_wdata = {1'b0, init_idx_q} + LW'(1);
			end
			S_ADD: begin
				lnk_we    = 1'b1;
				lnk_addr  = free_head_q[SW-1:0];
				lnk_wdata = list_head_q;
			end
			S_WALK: begin
				lnk_we    = hit && (req_q == REQ_REMOVE) && (prev_q < NULL_LINK);
				lnk_addr  = prev_q[SW-1:0];
				lnk_wdata = rd_link;
			end
			S_FREE: begin
				lnk_we = 1'b1;
			end
			default: begin
				lnk_we = 1'b0;
			end
		endcase
	end

	alm_store #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_value  (rd_value),
		.rd_link   (rd_link),
		.val_we    (val_we),
		.val_addr  (free_head_q[SW-1:0]),
		.val_wdata (val_q),
		.lnk_we    (lnk_we),
		.lnk_addr  (lnk_addr),
		.lnk_wdata (lnk_wdata)
	);

	// Request sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_idx_q  <= '0;
			list_head_q <= NULL_LINK;
			free_head_q <= '0;
			total_q     <= '0;
			req_q       <= REQ_ADD;
			val_q       <= '0;
			cur_q       <= NULL_LINK;
			prev_q      <= NULL_LINK;
			steps_q     <= '0;
			found_q     <= '0;
			status_q    <= ST_DONE;
			rsp_valid_q <= 1'b0;
			rsp_word_q  <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					init_idx_q <= init_idx_q + SW'(1);
					if (init_idx_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_q   <= req_word.req_type;
						val_q   <= in_val;
						cur_q   <= list_head_q;
						prev_q  <= NULL_LINK;
						steps_q <= '0;
						found_q <= '0;
						if (req_word.req_type == REQ_ADD) begin
							if (free_head_q < NULL_LINK) begin
								status_q <= ST_DONE;
								state_q  <= S_ADD;
							end else begin
								status_q <= ST_FULL;
								state_q  <= S_FIN;
							end
						end else if (list_head_q < NULL_LINK) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_ADD: begin
					free_head_q <= rd_link;
					list_head_q <= free_head_q;
					total_q     <= total_q + CW'(1);
					state_q     <= S_FIN;
				end
				S_WALK: begin
					if (hit) begin
						found_q <= found_q + CW'(1);
					end
					if (hit && req_q == REQ_REMOVE) begin
						if (prev_q >= NULL_LINK) begin
							list_head_q <= rd_link;
						end
						if (total_q != '0) begin
							total_q <= total_q - CW'(1);
						end
						state_q <= S_FREE;
					end else if ((hit && req_q == REQ_SEARCH) || walk_stop) begin
						state_q <= S_FIN;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rd_link;
						steps_q <= next_steps;
					end
				end
				S_FREE: begin
					free_head_q <= cur_q;
					state_q     <= S_FIN;
				end
				S_FIN: begin
					if (rsp_free) begin
						rsp_valid_q            <= 1'b1;
						rsp_word_q.status      <= fin_status;
						rsp_word_q.occurrences <= (req_q == REQ_COUNT) ? COUNT_W'(found_q)
						                                               : '0;
						rsp_word_q.elem_total  <= COUNT_W'(total_q);
						rsp_word_q.is_empty    <= (total_q == '0);
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
